// ===== hw/rtl/hqx_pkg.sv =====
// ----------------------------------------------------------------------------
// hqx_pkg
// Shared types and constants of the hqx neighbor pattern block.
// ----------------------------------------------------------------------------
package hqx_pkg;

    // packed YUV pixel, 8 bits per channel
    typedef struct packed {
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
    } t_yuv;

    // one column of three pixels, index 0 top, 1 middle, 2 bottom
    typedef t_yuv [2:0] t_col;

    // work handed from the front to the back for one accepted item
    typedef struct packed {
        t_col left;
        t_col center;
        t_col right;
        logic first;
        logic last;
    } t_job;

    // similarity thresholds
    typedef struct packed {
        logic [7:0] luma;
        logic [7:0] u;
        logic [7:0] v;
    } t_thresh;

    // configuration register indexes
    localparam logic [1:0] CFG_LUMA_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_U_THRESHOLD    = 2'd1;
    localparam logic [1:0] CFG_V_THRESHOLD    = 2'd2;

    // threshold reset values
    localparam logic [7:0] RESET_LUMA_THRESHOLD = 8'd48;
    localparam logic [7:0] RESET_U_THRESHOLD    = 8'd7;
    localparam logic [7:0] RESET_V_THRESHOLD    = 8'd6;

endpackage

// ===== hw/rtl/hqx_front.sv =====
// ----------------------------------------------------------------------------
// hqx_front
// Accepts pixel columns, converts them to YUV, tracks the row window and
// queues one job per item.
// ----------------------------------------------------------------------------
module hqx_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [71:0]   i_pixels,      // top, middle, bottom RGB from low bits
    input  logic          i_first,
    input  logic          i_last,
    input  logic          i_queue_full,
    output logic          o_push,
    output hqx_pkg::t_job o_job
);
    import hqx_pkg::*;

    // RGB to YUV with floor shifts, all channels land in 8 bits
    function automatic t_yuv to_yuv(input logic [23:0] rgb);
        logic [9:0]  sum_y;
        logic [8:0]  diff_u;
        logic [9:0]  diff_v;
        t_yuv        res;
        sum_y   = {2'b00, rgb[23:16]} + {2'b00, rgb[15:8]} + {2'b00, rgb[7:0]};
        diff_u  = {1'b0, rgb[23:16]} + 9'd256 - {1'b0, rgb[7:0]};
        diff_v  = 10'd512 + {1'b0, rgb[15:8], 1'b0} - {2'b00, rgb[23:16]}
                  - {2'b00, rgb[7:0]};
        res.y   = sum_y[9:2];
        res.u   = 8'd64 + {1'b0, diff_u[8:2]};
        res.v   = 8'd64 + {1'b0, diff_v[9:3]};
        return res;
    endfunction

    t_col r_left;
    t_col r_center;
    logic r_center_valid;
    t_col w_col;
    logic w_first;
    logic w_accept;

    // column conversion and row start decision
    always_comb begin
        w_col[0] = to_yuv(i_pixels[23:0]);
        w_col[1] = to_yuv(i_pixels[47:24]);
        w_col[2] = to_yuv(i_pixels[71:48]);
        w_first  = i_first | ~r_center_valid;
    end

    assign o_ready  = ~i_queue_full;
    assign w_accept = i_valid & o_ready;
    assign o_push   = w_accept;

    // job: a row start sees its own column on every side
    always_comb begin
        o_job.left   = w_first ? w_col : r_left;
        o_job.center = w_first ? w_col : r_center;
        o_job.right  = w_col;
        o_job.first  = w_first;
        o_job.last   = i_last;
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left         <= '0;
            r_center       <= '0;
            r_center_valid <= 1'b0;
        end else if (w_accept) begin
            r_left         <= w_first ? w_col : r_center;
            r_center       <= w_col;
            r_center_valid <= ~i_last;
        end
    end

endmodule

// ===== hw/rtl/hqx_queue.sv =====
// ----------------------------------------------------------------------------
// hqx_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module hqx_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hqx_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_head_valid,
    output hqx_pkg::t_job o_head
);
    import hqx_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/hqx_back.sv =====
// ----------------------------------------------------------------------------
// hqx_back
// Holds the thresholds, compares window pixels and emits one pattern per
// cycle through the output register while a job waits and no stall holds.
// ----------------------------------------------------------------------------
module hqx_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_head_valid,
    input  hqx_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_pattern,
    output logic          o_last
);
    import hqx_pkg::*;

    typedef enum logic [1:0] {
        STEP_MAIN,
        STEP_EDGE,
        STEP_PAD
    } t_step;

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic differs(input t_yuv a, input t_yuv b, input t_thresh th);
        return (abs_diff(a.y, b.y) > th.luma) || (abs_diff(a.u, b.u) > th.u) ||
               (abs_diff(a.v, b.v) > th.v);
    endfunction

    function automatic logic [7:0] full_pattern(input t_col l, input t_col c,
                                                input t_col r, input t_thresh th);
        logic [7:0] p;
        p[0] = differs(c[1], l[0], th);
        p[1] = differs(c[1], c[0], th);
        p[2] = differs(c[1], r[0], th);
        p[3] = differs(c[1], l[1], th);
        p[4] = differs(c[1], r[1], th);
        p[5] = differs(c[1], l[2], th);
        p[6] = differs(c[1], c[2], th);
        p[7] = differs(c[1], r[2], th);
        return p;
    endfunction

    function automatic logic [7:0] pad_pattern(input t_col c, input t_thresh th);
        logic [7:0] p;
        p      = '0;
        p[2:0] = {3{differs(c[1], c[0], th)}};
        p[7:5] = {3{differs(c[1], c[2], th)}};
        return p;
    endfunction

    t_thresh    r_thresh;
    t_step      r_step;
    t_step      n_step;
    logic       r_valid;
    logic [7:0] r_pattern;
    logic [7:0] n_pattern;
    logic       r_last;
    logic       n_last;
    logic       w_advance;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.luma <= RESET_LUMA_THRESHOLD;
            r_thresh.u    <= RESET_U_THRESHOLD;
            r_thresh.v    <= RESET_V_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LUMA_THRESHOLD: r_thresh.luma <= i_cfg_data;
                CFG_U_THRESHOLD:    r_thresh.u    <= i_cfg_data;
                CFG_V_THRESHOLD:    r_thresh.v    <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    // a job waits and the output register is free or draining this cycle
    assign w_advance = i_head_valid & (~r_valid | i_ready);

    // pattern of the current step; a row end walks through edge and pad
    always_comb begin
        n_pattern = '0;
        n_last    = 1'b1;
        n_step    = STEP_MAIN;
        case (r_step)
            STEP_MAIN: begin
                n_pattern = i_head.first ? pad_pattern(i_head.right, r_thresh)
                          : full_pattern(i_head.left, i_head.center, i_head.right,
                                         r_thresh);
                n_last    = ~i_head.last;
                n_step    = i_head.last ? STEP_EDGE : STEP_MAIN;
            end
            STEP_EDGE: begin
                n_pattern = full_pattern(i_head.center, i_head.right, i_head.right,
                                         r_thresh);
                n_last    = 1'b0;
                n_step    = STEP_PAD;
            end
            STEP_PAD: begin
                n_pattern = pad_pattern(i_head.right, r_thresh);
                n_last    = 1'b1;
                n_step    = STEP_MAIN;
            end
            default: begin
                n_pattern = '0;
                n_last    = 1'b1;
                n_step    = STEP_MAIN;
            end
        endcase
    end

    assign o_pop = w_advance & n_last;

    // step sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_MAIN;
            r_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_step    <= n_step;
                r_valid   <= 1'b1;
                r_pattern <= n_pattern;
                r_last    <= n_last;
            end else if (i_ready) begin
                r_valid   <= 1'b0;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_pattern = r_pattern;
    assign o_last    = r_last;

endmodule

// ===== hw/rtl/hqx_neighbor_pattern_top.sv =====
// ----------------------------------------------------------------------------
// hqx_neighbor_pattern_top
// Neighbor difference pattern generator over a streamed 3x3 YUV window.
// ----------------------------------------------------------------------------
// One pixel column (above, current and below row) is taken per clock while
// the job queue has room. Each item gives one 8-bit pattern, except the
// column that ends a row, which gives three patterns (its left neighbor's
// pattern, its own and a trailing padding pattern), the last one flagged by
// tlast. The result port delivers at most one pattern per clock from a
// single output register, so while results do not stall the sustained rate
// is one column per clock inside a row; a job queue of QUEUE_DEPTH entries
// between the input side and the compare side lets input keep flowing
// while results stall or a row end drains. Thresholds must be written by
// the user through the configuration channel while the block is idle; the
// block itself does not enforce this. No clearing pass is needed after reset.
module hqx_neighbor_pattern_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // pixel columns in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // top_pixel, middle_pixel, bottom_pixel
    input  logic        s_axis_tuser,   // first_in_row
    input  logic        s_axis_tlast,   // last_in_row
    // patterns out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // pattern
    output logic        m_axis_tlast    // last_of_run
);
    import hqx_pkg::*;

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_head_valid;
    t_job w_job;
    t_job w_head;

    assign o_cfg_ready = 1'b1;

    hqx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pixels     (s_axis_tdata),
        .i_first      (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_job)
    );

    hqx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_job),
        .o_full       (w_full),
        .i_pop        (w_pop),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    hqx_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_pattern    (m_axis_tdata),
        .o_last       (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/hqx_checker.sv =====
// ----------------------------------------------------------------------------
// hqx_checker
// Port level checks of the neighbor pattern block, bound to the top level.
// ----------------------------------------------------------------------------
module hqx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // no result shows right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result item changed");

    // configuration writes never stall
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind hqx_neighbor_pattern_top hqx_checker u_hqx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hqx neighbor pattern block.
// ----------------------------------------------------------------------------
// Streams pixel columns into the block and predicts every pattern from its
// own model of the YUV conversion, the threshold compare and the 3x3 window.
// Covers channel extremes, threshold boundaries, row starts and ends in all
// combinations, single-column rows, threshold sweeps including both extremes,
// random rows with noisy framing, back-to-back traffic and drained pauses.
// Both sides stall at random. Results are checked in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import hqx_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int IDLE_PCT      = 34;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 100000;

    // one expected pattern item
    typedef struct packed {
        logic [7:0] pattern;
        logic       last;
    } t_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = CFG_LUMA_THRESHOLD;
    logic [7:0]  i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;   // top_pixel, middle_pixel, bottom_pixel
    logic        s_axis_tuser  = 1'b0; // first_in_row
    logic        s_axis_tlast  = 1'b0; // last_in_row
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // pattern
    logic        m_axis_tlast;         // last_of_run

    // predictor state
    t_thresh thr;
    t_col    left_col;
    t_col    center_col;
    logic    row_open;
    t_result pending_patterns[$];

    int   errors     = 0;
    int   cycles     = 0;
    int   items_sent = 0;
    logic steady     = 1'b0;

    hqx_neighbor_pattern_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Pattern predictor
    // ------------------------------------------------------------------
    function automatic t_yuv rgb_to_yuv(logic [23:0] rgb);
        int   r, g, b;
        t_yuv p;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        // offsets keep the shifted terms positive, i.e. floor shifts
        p.y = 8'((r + g + b) >> 2);
        p.u = 8'(64 + ((r + 256 - b) >> 2));
        p.v = 8'(64 + ((512 + 2 * g - r - b) >> 3));
        return p;
    endfunction

    function automatic logic pixels_differ(t_yuv a, t_yuv b);
        int dy, du, dv;
        dy = int'(a.y) - int'(b.y);
        du = int'(a.u) - int'(b.u);
        dv = int'(a.v) - int'(b.v);
        if (dy < 0) dy = -dy;
        if (du < 0) du = -du;
        if (dv < 0) dv = -dv;
        return (dy > int'(thr.luma)) || (du > int'(thr.u)) || (dv > int'(thr.v));
    endfunction

    function automatic logic [7:0] window_pattern(t_col l, t_col c, t_col r);
        t_yuv       e;
        logic [7:0] p;
        e    = c[1];
        p[0] = pixels_differ(e, l[0]);
        p[1] = pixels_differ(e, c[0]);
        p[2] = pixels_differ(e, r[0]);
        p[3] = pixels_differ(e, l[1]);
        p[4] = pixels_differ(e, r[1]);
        p[5] = pixels_differ(e, l[2]);
        p[6] = pixels_differ(e, c[2]);
        p[7] = pixels_differ(e, r[2]);
        return p;
    endfunction

    // row-edge padding: vertical neighbors only, each fills its whole row
    function automatic logic [7:0] edge_pattern(t_col c);
        logic [7:0] p;
        p = '0;
        if (pixels_differ(c[1], c[0])) p[2:0] = 3'b111;
        if (pixels_differ(c[1], c[2])) p[7:5] = 3'b111;
        return p;
    endfunction

    function automatic void predict_column(logic [71:0] data, logic first, logic last);
        t_col    col;
        t_result res[$];
        col[0] = rgb_to_yuv(data[23:0]);
        col[1] = rgb_to_yuv(data[47:24]);
        col[2] = rgb_to_yuv(data[71:48]);
        // no open row means this column starts one, flagged or not
        if (first || !row_open) begin
            res.push_back('{edge_pattern(col), 1'b0});
            left_col   = col;
            center_col = col;
            row_open   = 1'b1;
        end else begin
            res.push_back('{window_pattern(left_col, center_col, col), 1'b0});
            left_col   = center_col;
            center_col = col;
        end
        // row end: own pattern with itself as right neighbor, then padding
        if (last) begin
            res.push_back('{window_pattern(left_col, center_col, center_col), 1'b0});
            res.push_back('{edge_pattern(center_col), 1'b0});
            row_open = 1'b0;
        end
        res[res.size() - 1].last = 1'b1;
        foreach (res[k]) pending_patterns.push_back(res[k]);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: config writes, accepted columns and result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LUMA_THRESHOLD: thr.luma = i_cfg_data;
                    CFG_U_THRESHOLD:    thr.u    = i_cfg_data;
                    CFG_V_THRESHOLD:    thr.v    = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_column(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_patterns.size() == 0) begin
                    $error("pattern item with none expected: pattern %02h last_of_run %0b",
                           m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    want = pending_patterns.pop_front();
                    if (m_axis_tdata !== want.pattern) begin
                        $error("pattern: expected %02h actual %02h", want.pattern, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_run: expected %0b actual %0b", want.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side backpressure
    always @(negedge i_clk)
        m_axis_tready = steady || ($urandom_range(99) >= IDLE_PCT);

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_column(logic [23:0] top, logic [23:0] mid, logic [23:0] bot,
                               logic first, logic last);
        @(negedge i_clk);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {bot, mid, top};
        s_axis_tuser  = first;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_patterns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [1:0] index, logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_thresholds(logic [7:0] luma, logic [7:0] u, logic [7:0] v);
        wait_results_drained();
        write_threshold(CFG_LUMA_THRESHOLD, luma);
        write_threshold(CFG_U_THRESHOLD, u);
        write_threshold(CFG_V_THRESHOLD, v);
    endtask

    // mostly close to the row's base color so that both outcomes show up
    function automatic logic [23:0] nearby_pixel(logic [23:0] base);
        int          mode, k;
        logic [23:0] p;
        mode = $urandom_range(9);
        if (mode < 3) begin
            p = base;
        end else if (mode < 7) begin
            for (k = 0; k < 3; k++)
                p[k*8 +: 8] = base[k*8 +: 8] + 8'($urandom_range(24)) - 8'd12;
        end else begin
            p = 24'($urandom);
        end
        return p;
    endfunction

    task automatic send_row(int len, logic noisy);
        logic [23:0] base;
        logic        first, last;
        int          k;
        base = 24'($urandom);
        for (k = 0; k < len; k++) begin
            first = (k == 0);
            last  = (k == len - 1);
            if (noisy) begin
                if ($urandom_range(9) == 0) first = ~first;
                if ($urandom_range(9) == 0) last  = ~last;
            end
            send_column(nearby_pixel(base), nearby_pixel(base), nearby_pixel(base),
                        first, last);
        end
    endtask

    task automatic run_random_rows(int count);
        int target;
        target = items_sent + count;
        while (items_sent < target)
            send_row(($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6),
                     $urandom_range(4) == 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // column without a row start right after reset
        send_column(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0);
        send_column(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0);
        send_column(24'hFF0000, 24'h00FF00, 24'h0000FF, 1'b0, 1'b0);
        send_column(24'h0000FF, 24'hFF00FF, 24'hFFFF00, 1'b0, 1'b1);
        // single-column row
        send_column(24'hFFFFFF, 24'h808080, 24'h000000, 1'b1, 1'b1);
        // row end with no row open
        send_column(24'h123456, 24'h123456, 24'h123456, 1'b0, 1'b1);
        // luma and U chroma right at and just past the default thresholds
        send_column(24'h404040, 24'h000000, 24'h424242, 1'b1, 1'b0);
        send_column(24'h414141, 24'h000000, 24'h404040, 1'b0, 1'b0);
        send_column(24'h000000, 24'h424242, 24'h1C0E00, 1'b0, 1'b0);
        send_column(24'h200E00, 24'h000000, 24'h1C0E00, 1'b0, 1'b0);
        // row start in the middle of a row drops the pending center
        send_column(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0);
        send_column(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b0);
        send_column(24'hFF00FF, 24'h00FF00, 24'hFF00FF, 1'b0, 1'b1);
        send_column(24'h010203, 24'hFEFDFC, 24'h7F807F, 1'b1, 1'b0);
        send_column(24'h808080, 24'h7F7F7F, 24'h818181, 1'b0, 1'b1);
    endtask

    task automatic test_threshold_extremes();
        set_thresholds(8'd0, 8'd0, 8'd0);
        run_random_rows(25);
        set_thresholds(8'd255, 8'd255, 8'd255);
        run_random_rows(25);
        set_thresholds(8'd0, 8'd255, 8'd255);
        run_random_rows(25);
        set_thresholds(8'd255, 8'd0, 8'd255);
        run_random_rows(25);
        set_thresholds(8'd255, 8'd255, 8'd0);
        run_random_rows(25);
    endtask

    task automatic test_random_thresholds();
        int k;
        for (k = 0; k < 3; k++) begin
            set_thresholds(8'($urandom_range(64)), 8'($urandom_range(16)),
                           8'($urandom_range(16)));
            run_random_rows(20);
        end
        set_thresholds(RESET_LUMA_THRESHOLD, RESET_U_THRESHOLD, RESET_V_THRESHOLD);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        run_random_rows(40);
        steady = 1'b0;
    endtask

    task automatic test_drained_pauses();
        int k;
        for (k = 0; k < 6; k++) begin
            send_row($urandom_range(1, 5), 1'b0);
            wait_results_drained();
        end
    endtask

    task automatic test_random_stream();
        run_random_rows(80);
    endtask

    initial begin
        thr        = '{RESET_LUMA_THRESHOLD, RESET_U_THRESHOLD, RESET_V_THRESHOLD};
        left_col   = '0;
        center_col = '0;
        row_open   = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_threshold_extremes();
        test_random_thresholds();
        test_back_to_back();
        test_drained_pauses();
        test_random_stream();

        wait_results_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
